@@ hw/rtl/base64url_stream_codec_macros.svh @@
// assertion helpers for the checker file
`ifndef BASE64URL_STREAM_CODEC_MACROS_SVH
`define BASE64URL_STREAM_CODEC_MACROS_SVH

// clocked property, muted while reset is asserted
`define B64URL_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must hold at every clock edge out of reset
`define B64URL_ASSERT_ALWAYS(lbl, cond, msg) \
    `B64URL_ASSERT_CLK(lbl, (1'b1 |-> (cond)), msg)

`endif

@@ hw/rtl/b64url_pkg.sv @@
package b64url_pkg;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic       error;
    } t_res;

    // one queue entry: the results caused by one input request
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_entry;

    // configuration write toward the front
    typedef struct packed {
        logic wr;
        logic mode;
    } t_cfg;

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_THIRD,
        POS_FOURTH
    } t_pos;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam int unsigned CFG_ADDR_W   = 3;
    localparam logic        CFG_IDX_MODE = 1'b0;

    // six-bit value to url-safe alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] six);
        logic [7:0] wide;
        logic [7:0] ch;
        wide = {2'b00, six};
        if (six < 6'd26) begin
            ch = 8'h41 + wide;
        end else if (six < 6'd52) begin
            ch = 8'h61 + wide - 8'd26;
        end else if (six < 6'd62) begin
            ch = 8'h30 + wide - 8'd52;
        end else if (six == 6'd62) begin
            ch = 8'h2D;
        end else begin
            ch = 8'h5F;
        end
        return ch;
    endfunction

    // character to {valid, six-bit value}; both url-safe and standard symbols accepted
    function automatic logic [6:0] dec_char(input logic [7:0] ch);
        logic [7:0] val;
        logic       ok;
        val = 8'd0;
        ok  = 1'b1;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            val = ch - 8'h41;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            val = ch - 8'h61 + 8'd26;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            val = ch - 8'h30 + 8'd52;
        end else if (ch == 8'h2D || ch == 8'h2B) begin
            val = 8'd62;
        end else if (ch == 8'h5F || ch == 8'h2F) begin
            val = 8'd63;
        end else begin
            ok = 1'b0;
        end
        return {ok, val[5:0]};
    endfunction

endpackage

@@ hw/rtl/b64url_front.sv @@
module b64url_front
    import b64url_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_room,
    output logic       o_ready,
    output logic       o_push,
    output t_entry     o_entry,
    output logic       o_mode
);

    logic        r_mode;
    t_pos        r_pos;
    logic [17:0] r_acc;
    logic        r_stopped;

    t_pos        n_pos;
    logic [17:0] n_acc;
    logic        n_stopped;

    logic        accept;
    logic [1:0]  cnt;
    t_res        res_a;
    t_res        res_b;
    logic        dec_ok;
    logic [5:0]  dec_val;
    logic        err;
    logic [5:0]  grp_a;
    logic [5:0]  grp_b;
    logic [5:0]  grp_c;

    assign o_ready = i_room;
    assign accept  = i_valid & i_room;
    assign o_mode  = r_mode;

    assign {dec_ok, dec_val} = dec_char(i_byte);
    assign grp_a = r_acc[17:12];
    assign grp_b = r_acc[11:6];
    assign grp_c = r_acc[5:0];

    always_comb begin
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_stopped = r_stopped;
        cnt       = 2'd0;
        res_a     = '0;
        res_b     = '0;

        if (r_mode == MODE_ENCODE) begin
            case (r_pos)
                POS_FIRST: begin
                    res_a.data = enc_char(i_byte[7:2]);
                    n_acc      = {16'd0, i_byte[1:0]};
                    n_pos      = POS_SECOND;
                    cnt        = 2'd1;
                    if (i_last) begin
                        res_b.data = enc_char({i_byte[1:0], 4'd0});
                        cnt        = 2'd2;
                    end
                end
                POS_SECOND: begin
                    res_a.data = enc_char({r_acc[1:0], i_byte[7:4]});
                    n_acc      = {14'd0, i_byte[3:0]};
                    n_pos      = POS_THIRD;
                    cnt        = 2'd1;
                    if (i_last) begin
                        res_b.data = enc_char({i_byte[3:0], 2'd0});
                        cnt        = 2'd2;
                    end
                end
                default: begin
                    res_a.data = enc_char({r_acc[3:0], i_byte[7:6]});
                    res_b.data = enc_char(i_byte[5:0]);
                    cnt        = 2'd2;
                    n_acc      = '0;
                    n_pos      = POS_FIRST;
                end
            endcase
        end else if (!r_stopped) begin
            case (r_pos)
                POS_FIRST: begin
                    if (!dec_ok) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_acc = {dec_val, 12'd0};
                        n_pos = POS_SECOND;
                    end
                end
                POS_SECOND: begin
                    if (!dec_ok) begin
                        n_stopped = 1'b1;
                    end else begin
                        res_a.data = {grp_a, dec_val[5:4]};
                        cnt        = 2'd1;
                        n_acc      = {grp_a, dec_val, 6'd0};
                        n_pos      = POS_THIRD;
                    end
                end
                POS_THIRD: begin
                    // a bad third character stands in as 0b000011
                    if (dec_ok) begin
                        res_a.data = {grp_b[3:0], dec_val[5:2]};
                        cnt        = 2'd1;
                        n_acc      = {grp_a, grp_b, dec_val};
                    end else begin
                        n_acc = {grp_a, grp_b, 6'd3};
                    end
                    n_pos = POS_FOURTH;
                end
                default: begin
                    if (dec_ok) begin
                        res_a.data = {grp_c[1:0], dec_val};
                        cnt        = 2'd1;
                    end
                    n_acc = '0;
                    n_pos = POS_FIRST;
                end
            endcase
        end

        res_a.has_byte = (cnt != 2'd0);
        res_b.has_byte = (cnt == 2'd2);
        err = (r_mode == MODE_DECODE) & n_stopped;

        if (i_last) begin
            case (cnt)
                2'd0: begin
                    res_a.data     = 8'd0;
                    res_a.has_byte = 1'b0;
                    res_a.last     = 1'b1;
                    res_a.error    = err;
                    cnt            = 2'd1;
                end
                2'd1: begin
                    res_a.last  = 1'b1;
                    res_a.error = err;
                end
                default: begin
                    res_b.last  = 1'b1;
                    res_b.error = err;
                end
            endcase
            n_pos     = POS_FIRST;
            n_acc     = '0;
            n_stopped = 1'b0;
        end
    end

    assign o_push        = accept & (cnt != 2'd0);
    assign o_entry.two   = (cnt == 2'd2);
    assign o_entry.r0    = res_a;
    assign o_entry.r1    = res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ENCODE;
            r_pos     <= POS_FIRST;
            r_acc     <= '0;
            r_stopped <= 1'b0;
        end else if (i_cfg.wr) begin
            r_mode    <= i_cfg.mode;
            r_pos     <= POS_FIRST;
            r_acc     <= '0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_stopped <= n_stopped;
        end
    end

endmodule

@@ hw/rtl/b64url_queue.sv @@
module b64url_queue
    import b64url_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty,
    output logic   o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;

    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/b64url_back.sv @@
module b64url_back
    import b64url_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_entry i_entry,
    output logic   o_pop,
    input  logic   i_out_ready,
    output logic   o_out_valid,
    output t_res   o_res
);

    logic r_valid;
    t_res r_out;
    logic r_hold_v;
    t_res r_hold;

    logic load;

    // the output register takes a new result when empty or being drained
    assign load  = ~r_valid | i_out_ready;
    assign o_pop = load & ~r_hold_v & ~i_empty;

    assign o_out_valid = r_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (load) begin
            r_valid <= r_hold_v | ~i_empty;
            if (r_hold_v) begin
                r_hold_v <= 1'b0;
            end else if (!i_empty) begin
                r_hold_v <= i_entry.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_hold_v) begin
                r_out <= r_hold;
            end else if (!i_empty) begin
                r_out  <= i_entry.r0;
                r_hold <= i_entry.r1;
            end
        end
    end

endmodule

@@ hw/rtl/base64url_stream_codec.sv @@
// base64url codec (url-safe alphabet, no padding) on a byte stream. codec_mode
// at byte address 0 selects encode (0) or decode (1); writing it also restarts
// the stream, so write it only while no request is in flight. encode turns each
// three bytes into four characters and flushes a partial group as two or three
// characters on the request marked tlast. decode takes A-Z a-z 0-9 - _ + / and
// emits each byte as soon as its bits are known; a bad first or second
// character of a group silences the rest of the stream and its closing result
// carries the error flag. the final result of a stream always has tlast set and
// may carry no byte. an input request is taken every cycle while the result
// queue has room, and the output side delivers one result per cycle while the
// master side is ready, so encode, with four characters for every three input
// bytes, is limited by the output port and decode runs at one character per
// cycle. the results of a request enter the queue at the edge that takes it,
// and show on the master side once the output register loads them from it.
module base64url_stream_codec
    import b64url_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    input  logic                  s_axis_tlast,

    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]            m_axis_tuser,   // [0] out_has_byte, [1] out_error
    output logic                  m_axis_tlast,

    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg   cfg;
    logic   mode;
    logic   reg_sel;
    logic   push;
    t_entry wr_entry;
    t_entry rd_entry;
    logic   q_empty;
    logic   q_full;
    logic   pop;
    t_res   res;

    // register decode: one register, index taken from the word address
    assign pready   = 1'b1;
    assign reg_sel  = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_MODE);
    assign cfg.wr   = psel & penable & pwrite & pready & reg_sel;
    assign cfg.mode = pwdata[0];
    assign prdata   = reg_sel ? {31'd0, mode} : 32'd0;

    // front: accepts requests, tracks group position, builds up to two results
    b64url_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_room  (~q_full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_entry (wr_entry),
        .o_mode  (mode)
    );

    // queue of per-request result pairs between front and back
    b64url_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (wr_entry),
        .i_pop   (pop),
        .o_entry (rd_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: serializes the pairs into one result per cycle while the output is ready
    b64url_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_entry     (rd_entry),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_res       (res)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tuser = {res.error, res.has_byte};
    assign m_axis_tlast = res.last;

endmodule

@@ hw/rtl/b64url_checker.sv @@
`include "base64url_stream_codec_macros.svh"

module b64url_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // nothing comes out right after reset
    `B64URL_ASSERT_CLK(a_quiet_after_reset, $past(!i_rst_n) |-> !m_axis_tvalid,
        "result right after reset")

    // a result without a byte is only the closing one, with zero data
    `B64URL_ASSERT_ALWAYS(a_empty_closes,
        !(m_axis_tvalid && !m_axis_tuser[0]) || (m_axis_tlast && m_axis_tdata == 8'd0),
        "empty result not closing")

    // error flag only on an empty closing result
    `B64URL_ASSERT_ALWAYS(a_error_closes,
        !(m_axis_tvalid && m_axis_tuser[1]) || (m_axis_tlast && !m_axis_tuser[0]),
        "error on a data result")

    // a stalled result holds
    `B64URL_ASSERT_CLK(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "stalled result changed")

endmodule

bind base64url_stream_codec b64url_checker u_checker (.*);
